[src/sle_pkg.sv]
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants of the sorted list engine
// Holds the store size, the command codes and the control word that the
// top level broadcasts along the row of cells.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int Capacity = 16;
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int IdxW     = $clog2(Capacity);
  localparam int KeyW     = 32;

  typedef logic signed [KeyW-1:0] key_t;
  typedef logic [CntW-1:0]        cnt_t;
  typedef logic [IdxW-1:0]        idx_t;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_FIND   = 3'd2,
    CMD_UPDATE = 3'd3,
    CMD_POP    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_POP    = 2'd3
  } op_e;

  typedef struct packed {
    op_e  op;
    key_t key;
  } cell_ctrl_t;

endpackage

[src/sorted_list_engine.sv]
// ----------------------------------------------------------------------------
// sorted_list_engine: bounded ascending multiset of signed keys
// A row of cells keeps the keys in order and shifts them all together.
// ----------------------------------------------------------------------------
// Input beats on the s_axis channel carry a command in tuser (0 insert,
// 1 remove, 2 find, 3 update, 4 pop smallest) and the key and the update's
// new key in tdata. Every input beat gives exactly one result beat on the
// m_axis channel: a success flag, the smallest and largest stored key
// (0 when empty), the count and the empty and full flags, all after the
// command has taken effect.
// The command acts on the row of cells in the cycle of acceptance; the
// result is then registered in ST_REPORT once the output register is
// free. An update passes through ST_INS2 before ST_REPORT, its removal
// and its insertion each using one shift of the row. Input is taken again
// once the result has gone to the output register.
// Reset empties the store at once; no clearing pass is needed.
// While the receiver stalls one result waits in the output register; the
// next item is still accepted and worked on, and its result is held back
// until the output register is free.
// ----------------------------------------------------------------------------
module sorted_list_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // key[31:0], new_key[63:32]
  input  logic [2:0]  s_axis_tuser,  // cmd[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata   // ok[0], front_key[32:1], rear_key[64:33],
                                     // count[69:65], is_empty[70], is_full[71]
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_INS2   = 3'b010,
    ST_REPORT = 3'b100
  } state_e;

  state_e              state_q, state_d;
  sle_pkg::cnt_t       count_q, count_d;
  logic                ok_q, ok_d;
  sle_pkg::key_t       nkey_q, nkey_d;
  logic                out_valid_q, out_valid_d;
  logic [71:0]         out_data_q, out_data_d;

  sle_pkg::cell_ctrl_t ctrl;
  sle_pkg::key_t       keys   [sle_pkg::Capacity];
  logic                place  [sle_pkg::Capacity];
  logic [sle_pkg::Capacity-1:0] match;
  logic [sle_pkg::Capacity-1:0] occ;

  logic                accept;
  logic                found;
  logic                full;
  logic                empty;
  sle_pkg::idx_t       last_idx;
  sle_pkg::key_t       front_key;
  sle_pkg::key_t       rear_key;
  logic                out_free;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign found  = |match;
  assign full   = (count_q == sle_pkg::CntW'(sle_pkg::Capacity));
  assign empty  = (count_q == '0);

  genvar gi;
  generate
    for (gi = 0; gi < sle_pkg::Capacity; gi++) begin : g_cell
      sle_pkg::key_t left_key;
      logic          left_place;
      sle_pkg::key_t right_key;

      assign occ[gi] = (sle_pkg::CntW'(gi) < count_q);

      if (gi == 0) begin : g_first
        assign left_key   = '0;
        assign left_place = 1'b0;
      end else begin : g_mid
        assign left_key   = keys[gi-1];
        assign left_place = place[gi-1];
      end

      if (gi == sle_pkg::Capacity - 1) begin : g_last
        assign right_key = keys[gi];
      end else begin : g_inner
        assign right_key = keys[gi+1];
      end

      sle_cell u_cell (
        .clk_i        (clk_i),
        .ctrl_i       (ctrl),
        .occ_i        (occ[gi]),
        .left_key_i   (left_key),
        .left_place_i (left_place),
        .right_key_i  (right_key),
        .key_o        (keys[gi]),
        .place_o      (place[gi]),
        .match_o      (match[gi])
      );
    end
  endgenerate

  assign last_idx  = sle_pkg::IdxW'(count_q - sle_pkg::CntW'(1));
  assign front_key = empty ? '0 : keys[0];
  assign rear_key  = empty ? '0 : keys[last_idx];
  assign out_free  = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ok_d        = ok_q;
    nkey_d      = nkey_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    ctrl.op     = sle_pkg::OP_HOLD;
    ctrl.key    = (state_q == ST_INS2) ? nkey_q : s_axis_tdata[31:0];

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ok_d    = 1'b0;
          state_d = ST_REPORT;
          case (s_axis_tuser)
            sle_pkg::CMD_INSERT: begin
              if (!full) begin
                ctrl.op = sle_pkg::OP_INSERT;
                count_d = count_q + sle_pkg::CntW'(1);
                ok_d    = 1'b1;
              end
            end
            sle_pkg::CMD_REMOVE: begin
              if (found) begin
                ctrl.op = sle_pkg::OP_REMOVE;
                count_d = count_q - sle_pkg::CntW'(1);
                ok_d    = 1'b1;
              end
            end
            sle_pkg::CMD_FIND: begin
              ok_d = found;
            end
            sle_pkg::CMD_UPDATE: begin
              if (found) begin
                ctrl.op = sle_pkg::OP_REMOVE;
                count_d = count_q - sle_pkg::CntW'(1);
                ok_d    = 1'b1;
                nkey_d  = s_axis_tdata[63:32];
                state_d = ST_INS2;
              end
            end
            sle_pkg::CMD_POP: begin
              if (!empty) begin
                ctrl.op = sle_pkg::OP_POP;
                count_d = count_q - sle_pkg::CntW'(1);
                ok_d    = 1'b1;
              end
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end
      ST_INS2: begin
        ctrl.op = sle_pkg::OP_INSERT;
        count_d = count_q + sle_pkg::CntW'(1);
        state_d = ST_REPORT;
      end
      ST_REPORT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {full, empty, 5'(count_q), rear_key, front_key, ok_q};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ok_q        <= ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nkey_q     <= nkey_d;
    out_data_q <= out_data_d;
  end

endmodule

[src/sle_cell.sv]
// ----------------------------------------------------------------------------
// sle_cell: one slot of the sorted row
// Holds one key, compares it with the broadcast key and takes its own key,
// the broadcast key or a neighbour's key as the row shifts.
// ----------------------------------------------------------------------------
module sle_cell (
  input  logic                clk_i,
  input  sle_pkg::cell_ctrl_t ctrl_i,
  input  logic                occ_i,
  input  sle_pkg::key_t       left_key_i,
  input  logic                left_place_i,
  input  sle_pkg::key_t       right_key_i,
  output sle_pkg::key_t       key_o,
  output logic                place_o,
  output logic                match_o
);

  sle_pkg::key_t key_q, key_d;

  // this slot lies at or past the insertion point
  assign place_o = !occ_i || (ctrl_i.key < key_q);
  assign match_o = occ_i && (ctrl_i.key == key_q);
  assign key_o   = key_q;

  always_comb begin
    key_d = key_q;
    case (ctrl_i.op)
      sle_pkg::OP_INSERT: begin
        if (left_place_i) begin
          key_d = left_key_i;
        end else if (place_o) begin
          key_d = ctrl_i.key;
        end
      end
      sle_pkg::OP_REMOVE: begin
        if (occ_i && !(key_q < ctrl_i.key)) begin
          key_d = right_key_i;
        end
      end
      sle_pkg::OP_POP: begin
        key_d = right_key_i;
      end
      default: begin
        key_d = key_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule
